FILE: src/sedd_pkg.sv
package sedd_pkg;

   localparam int WORD_W        = 32;
   localparam int COUNT_W       = 26;
   localparam int CHAN_W        = 5;
   localparam int TRIG_NUM_W    = 16;
   localparam int TRIG_TYPE_W   = 2;
   localparam int WCOUNT_W      = 6;
   localparam int KIND_W        = 3;
   localparam int CSR_INDEX_W   = 1;

   localparam int TOP_LSB       = 27;
   localparam int MARK_POS      = 26;
   localparam int WCOUNT_LSB    = 18;
   localparam int TYPE_LSB      = 16;

   localparam int DEFAULT_NUM_CHANNELS = 32;
   localparam logic [COUNT_W-1:0] MAX_DELTA_RESET = COUNT_W'(200);

   localparam logic [CSR_INDEX_W-1:0] CSR_MODULE_GEO = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELTA  = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER   = 3'd0,
      KIND_GEO_MISS = 3'd1,
      KIND_DATA     = 3'd2,
      KIND_ABORT    = 3'd3,
      KIND_RANGE    = 3'd4
   } kind_type;

   // decoded word waiting for its counter table lookup
   typedef struct packed {
      kind_type                kind;
      logic [CHAN_W-1:0]       channel;
      logic [COUNT_W-1:0]      raw_count;
      logic [TRIG_NUM_W-1:0]   trigger_number;
      logic [TRIG_TYPE_W-1:0]  trigger_type;
      logic [WCOUNT_W-1:0]     channel_words;
      logic                    last;
   } stage_type;

   typedef struct packed {
      kind_type                kind;
      logic [CHAN_W-1:0]       channel;
      logic [COUNT_W-1:0]      raw_count;
      logic [COUNT_W-1:0]      delta;
      logic                    delta_valid;
      logic [TRIG_NUM_W-1:0]   trigger_number;
      logic [TRIG_TYPE_W-1:0]  trigger_type;
      logic [WCOUNT_W-1:0]     channel_words;
      logic                    last;
   } result_type;

endpackage

FILE: src/sedd_if.sv
interface sedd_req_if;
   logic                          valid;
   logic                          ready;
   logic [sedd_pkg::WORD_W-1:0]   word;

   modport source (output valid, output word, input ready);
   modport sink   (input valid, input word, output ready);
endinterface

interface sedd_rsp_if;
   logic                               valid;
   logic                               ready;
   sedd_pkg::kind_type                 kind;
   logic [sedd_pkg::CHAN_W-1:0]        channel;
   logic [sedd_pkg::COUNT_W-1:0]       raw_count;
   logic [sedd_pkg::COUNT_W-1:0]       delta;
   logic                               delta_valid;
   logic [sedd_pkg::TRIG_NUM_W-1:0]    trigger_number;
   logic [sedd_pkg::TRIG_TYPE_W-1:0]   trigger_type;
   logic [sedd_pkg::WCOUNT_W-1:0]      channel_words;
   logic                               last;

   modport source (output valid, output kind, output channel, output raw_count,
                   output delta, output delta_valid, output trigger_number,
                   output trigger_type, output channel_words, output last,
                   input ready);
   modport sink   (input valid, input kind, input channel, input raw_count,
                   input delta, input delta_valid, input trigger_number,
                   input trigger_type, input channel_words, input last,
                   output ready);
endinterface

FILE: src/sedd_ram.sv
module sedd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/sedd_decode.sv
module sedd_decode #(
   parameter int NUM_CHANNELS = sedd_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          accept,
   input  logic [sedd_pkg::WORD_W-1:0]                   word,
   input  logic [sedd_pkg::CHAN_W-1:0]                   module_geo,
   output logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
   output logic                                          s1_valid,
   output sedd_pkg::stage_type                           s1_item
);
   import sedd_pkg::*;

   localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

   logic [WCOUNT_W-1:0]    words_left_ff, words_left_in;
   logic [TRIG_NUM_W-1:0]  held_tn_ff, held_tn_in;
   logic [TRIG_TYPE_W-1:0] held_tt_ff, held_tt_in;
   logic                   s1_valid_ff;
   stage_type              s1_item_ff, item;

   logic [CHAN_W-1:0]      top;
   logic                   mark;
   logic [WCOUNT_W-1:0]    cnt;
   logic [WCOUNT_W-1:0]    left_dec;
   logic                   in_range;

   always_comb begin
      top      = word[TOP_LSB +: CHAN_W];
      mark     = word[MARK_POS];
      cnt      = mark ? word[WCOUNT_LSB +: WCOUNT_W] : '0;
      left_dec = words_left_ff - WCOUNT_W'(1);
      in_range = 32'(top) < NUM_CHANNELS;

      words_left_in = words_left_ff;
      held_tn_in    = held_tn_ff;
      held_tt_in    = held_tt_ff;
      item          = '0;
      item.kind     = KIND_HEADER;

      priority if (words_left_ff == '0) begin
         if (top != module_geo) begin
            item.kind = KIND_GEO_MISS;
            item.last = 1'b1;
         end else begin
            held_tn_in          = mark ? word[TRIG_NUM_W-1:0] : '0;
            held_tt_in          = mark ? word[TYPE_LSB +: TRIG_TYPE_W] : '0;
            words_left_in       = cnt;
            item.trigger_number = held_tn_in;
            item.trigger_type   = held_tt_in;
            item.channel_words  = cnt;
            item.last           = (cnt == '0);
         end
      end else if (mark) begin
         // header mark in the middle of an event aborts it
         words_left_in = '0;
         item.kind     = KIND_ABORT;
         item.last     = 1'b1;
      end else begin
         words_left_in       = left_dec;
         item.kind           = in_range ? KIND_DATA : KIND_RANGE;
         item.channel        = top;
         item.raw_count      = word[COUNT_W-1:0];
         item.trigger_number = held_tn_ff;
         item.trigger_type   = held_tt_ff;
         item.last           = (left_dec == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         words_left_ff <= '0;
         held_tn_ff    <= '0;
         held_tt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            words_left_ff <= words_left_in;
            held_tn_ff    <= held_tn_in;
            held_tt_ff    <= held_tt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= item;
      end
   end

   assign rd_addr  = top[AW-1:0];
   assign s1_valid = s1_valid_ff;
   assign s1_item  = s1_item_ff;

endmodule

FILE: src/sedd_delta.sv
module sedd_delta #(
   parameter int NUM_CHANNELS = sedd_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          rd_en,
   input  logic [(NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1)-1:0] rd_addr,
   input  logic                                          s1_valid,
   input  sedd_pkg::stage_type                           s1_item,
   input  logic [sedd_pkg::COUNT_W-1:0]                  max_delta,
   output sedd_pkg::result_type                          result
);
   import sedd_pkg::*;

   localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

   logic [NUM_CHANNELS-1:0] entry_valid_ff;
   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic [COUNT_W-1:0]      fwd_data_ff;

   logic [AW-1:0]           addr;
   logic                    wr_en;
   logic [COUNT_W-1:0]      rd_data;
   logic [COUNT_W-1:0]      prev;
   logic [COUNT_W-1:0]      diff;
   logic [COUNT_W-1:0]      sat;

   sedd_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_CHANNELS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (s1_item.raw_count),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      addr  = s1_item.channel[AW-1:0];
      wr_en = s1_valid && (s1_item.kind == KIND_DATA);

      // the ram read was issued while the previous word was writing back
      if (fwd_valid_ff && (fwd_addr_ff == addr)) begin
         prev = fwd_data_ff;
      end else if (entry_valid_ff[addr]) begin
         prev = rd_data;
      end else begin
         prev = '0;
      end

      diff = s1_item.raw_count - prev;
      sat  = (diff > max_delta) ? max_delta : diff;

      result.kind           = s1_item.kind;
      result.channel        = s1_item.channel;
      result.raw_count      = s1_item.raw_count;
      result.delta          = (s1_item.kind == KIND_DATA) ? sat : '0;
      result.delta_valid    = (s1_item.kind == KIND_DATA) && (sat != '0);
      result.trigger_number = s1_item.trigger_number;
      result.trigger_type   = s1_item.trigger_type;
      result.channel_words  = s1_item.channel_words;
      result.last           = s1_item.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         fwd_valid_ff   <= 1'b0;
      end else begin
         fwd_valid_ff <= wr_en;
         if (wr_en) begin
            entry_valid_ff[addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= addr;
         fwd_data_ff <= s1_item.raw_count;
      end
   end

endmodule

FILE: src/sedd_outq.sv
module sedd_outq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sedd_pkg::result_type  push_data,
   input  logic                  pop,
   output logic                  not_empty,
   output sedd_pkg::result_type  head,
   output logic [1:0]            count
);
   import sedd_pkg::*;

   localparam int DEPTH = 3;
   localparam int PW    = $clog2(DEPTH);

   result_type       entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      count_in = count_ff + (PW + 1)'(push) - (PW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff[1:0];

endmodule

FILE: src/scaler_event_delta_decoder.sv
// scaler event delta decoder
//
// req_chan carries 32-bit readout words of a scaler event: a header with geo
// address, channel word count and trigger fields, then one word per channel
// with a channel number and a 26-bit counter. rsp_chan returns one transaction
// per accepted word: header accepted, geo mismatch, channel data with the
// saturated counter change since the last word of that channel, abort on an
// unexpected header mark, or channel out of range.
// csr_* writes module_geo (index 0) and max_delta (index 1); the user must
// write them only while idle; the block does not enforce it.
// throughput: one word per cycle, sustained while rsp_chan.ready holds; the
// last-count table is a single-port-write, single-port-read ram and each word
// does one read in the accept cycle and, for channel data, one write-back in
// the next, with a bypass for a repeat of a channel in consecutive words.
// a word's result is formed in the cycle after it is accepted, then queued.
// a three-entry result queue decouples the sides: req_chan.ready drops only
// when the queue and the lookup stage together hold three transactions, so a
// stalled receiver backs up into the input after three words.
// reset clears the event state, both registers to their defaults and the
// per-channel valid bits, so every counter reads as zero at once; no sweep.
module scaler_event_delta_decoder #(
   parameter int NUM_CHANNELS = sedd_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   sedd_req_if.sink                            req_chan,
   sedd_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [sedd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sedd_pkg::COUNT_W-1:0]        csr_wr_data
);
   import sedd_pkg::*;

   localparam int AW = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;

   // configuration registers
   logic [CHAN_W-1:0]  module_geo_ff;
   logic [COUNT_W-1:0] max_delta_ff;

   logic               accept;
   logic [AW-1:0]      rd_addr;
   logic               s1_valid;
   stage_type          s1_item;
   result_type         result;
   result_type         head;
   logic               q_not_empty;
   logic [1:0]         q_count;
   logic               pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_geo_ff <= '0;
         max_delta_ff  <= MAX_DELTA_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MODULE_GEO: module_geo_ff <= csr_wr_data[CHAN_W-1:0];
            CSR_MAX_DELTA:  max_delta_ff  <= csr_wr_data;
         endcase
      end
   end

   // room in the result queue for the word in the lookup stage and the new one
   assign req_chan.ready = (3'(q_count) + 3'(s1_valid)) <= 3'd2;
   assign accept         = req_chan.valid && req_chan.ready;

   // header tracking and word decode; issues the table read
   sedd_decode #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .word       (req_chan.word),
      .module_geo (module_geo_ff),
      .rd_addr    (rd_addr),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item)
   );

   // table lookup, change computation and write-back
   sedd_delta #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_delta (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (rd_addr),
      .s1_valid  (s1_valid),
      .s1_item   (s1_item),
      .max_delta (max_delta_ff),
      .result    (result)
   );

   assign pop = q_not_empty && rsp_chan.ready;

   sedd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid),
      .push_data (result),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_chan.valid          = q_not_empty;
   assign rsp_chan.kind           = head.kind;
   assign rsp_chan.channel        = head.channel;
   assign rsp_chan.raw_count      = head.raw_count;
   assign rsp_chan.delta          = head.delta;
   assign rsp_chan.delta_valid    = head.delta_valid;
   assign rsp_chan.trigger_number = head.trigger_number;
   assign rsp_chan.trigger_type   = head.trigger_type;
   assign rsp_chan.channel_words  = head.channel_words;
   assign rsp_chan.last           = head.last;

   // queue never overflows when the lookup stage pushes
   assert property (@(posedge clock) disable iff (reset)
      s1_valid |-> (q_count != 2'd3))
      else $error("result queue overflow");

   // every accepted word reaches the lookup stage next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid)
      else $error("accepted word lost before lookup");

   // an abort or geo mismatch closes the event
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.kind == KIND_ABORT ||
                          rsp_chan.kind == KIND_GEO_MISS)) |-> rsp_chan.last)
      else $error("abort or mismatch without last");

   // only channel data carries a change
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != KIND_DATA) |->
         (rsp_chan.delta == '0 && !rsp_chan.delta_valid))
      else $error("change reported on a non-data transaction");

endmodule
